// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the jitter percentile RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on a given clock, with an active-low reset that disables it.
`define IJP_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on the module's clk_i / rst_ni.
`define IJP_ASSERT(lbl, prop, msg) `IJP_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)
`endif

// ===== hdl/ijp_pkg.sv =====
// Types and constants of the interval jitter percentile block.
// No dependencies; used by the top level and the error unit.
package ijp_pkg;

  localparam int unsigned RingDepthDef = 256;
  localparam int unsigned MinEntries   = 20;
  localparam logic [31:0] ErrorCap     = 32'd4000000000;
  localparam logic [19:0] UsPerSecond  = 20'd1000000;
  localparam logic [26:0] SampleRateRst = 27'd1000000;
  localparam logic [31:0] WindowRst    = 32'd1000000;
  localparam logic [6:0]  PctNum       = 7'd95;
  // ceil(2^32 / 100): exact floor(x / 100) for x below 2^30
  localparam logic [25:0] Recip100     = 26'd42949673;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  localparam logic CfgSampleRate = 1'b0;
  localparam logic CfgWindow     = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] host_us;
    logic [31:0] buf_samples;
  } req_t;

  typedef struct packed {
    logic [31:0] p95_error_us;
    logic        enough_samples;
  } result_t;

endpackage

// ===== hdl/interval_jitter_percentile_top.sv =====
// Top level of the interval jitter percentile block.
// Depends on ijp_pkg, ijp_ram, ijp_err and assert_macros.svh.
//
// Buffer arrival jitter tracker. A sample transaction (req_type 0) records a
// host timestamp; from the second one on, each stores the timestamp and the
// rounded interval error in a ring held in one RAM. A stored sample keeps busy
// high until the error unit is done: a 27-step shift-add multiply, a
// difference step, a 33-step restoring division and a registered done. The
// first sample after reset only arms the block and leaves busy low. A query
// transaction (req_type 1) answers the 95th percentile error of the ring
// entries whose age against the newest entry is within the window register.
// It reads the newest entry, counts the window in a pass over the RAM,
// computes the rank, then settles the answer one bit per pass over the RAM,
// 32 more passes, so busy stays high across all passes, bounded by the single
// RAM read port. With fewer than 20 entries in the window the query ends after
// the count pass. An empty ring answers in the cycle right after acceptance
// and never raises busy. Results appear for exactly one cycle with
// result_valid_o and the receiver cannot stall them; busy is already low in
// that same cycle. Write configuration only while busy is low.
module interval_jitter_percentile_top #(
  parameter int unsigned RingDepth = ijp_pkg::RingDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ijp_pkg::req_t     req_i,
  output logic              result_valid_o,
  output ijp_pkg::result_t  result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import ijp_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(RingDepth);
  localparam int unsigned CntW = $clog2(RingDepth + 1);
  localparam int unsigned XW   = CntW + 7;
  localparam int unsigned PW   = XW + 26;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SAMPLE = 7'b0000010,
    ST_NEWEST = 7'b0000100,
    ST_LOAD   = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_PASS   = 7'b0100000,
    ST_KCALC  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [26:0]      rate_q, rate_d;
  logic [31:0]      window_q, window_d;
  logic             armed_q, armed_d;
  logic [63:0]      prev_q, prev_d;
  logic [63:0]      host_q, host_d;
  logic [IdxW-1:0]  widx_q, widx_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  addr_q, addr_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             rv_q, rv_d;
  logic [63:0]      newest_q, newest_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             count_pass_q, count_pass_d;
  logic [XW-1:0]    x_q, x_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [31:0]      bit_q, bit_d;
  logic [31:0]      mask_q, mask_d;
  logic [31:0]      prefix_q, prefix_d;
  result_t          res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             accept;
  logic             err_start;
  logic             err_done;
  logic [31:0]      err_val;
  logic [95:0]      rd_data;
  logic [63:0]      rd_time;
  logic [31:0]      rd_err;
  logic [IdxW-1:0]  newest_slot;
  logic [IdxW-1:0]  addr_dec;
  logic             in_win;
  logic             hit;
  logic             issue;
  logic [PW-1:0]    kprod;
  logic             short_res;

  assign accept      = start && !busy;
  assign rd_time     = rd_data[95:32];
  assign rd_err      = rd_data[31:0];
  assign newest_slot = (widx_q == '0) ? IdxW'(RingDepth - 1) : widx_q - IdxW'(1);
  assign addr_dec    = (addr_q == '0) ? IdxW'(RingDepth - 1) : addr_q - IdxW'(1);
  assign in_win      = (newest_q - rd_time) <= {32'd0, window_q};
  // Count pass takes every windowed entry; bit passes take those that match
  // the prefix settled so far and have a zero in the bit under test.
  assign hit         = in_win && (count_pass_q ||
                       ((((rd_err ^ prefix_q) & mask_q) == '0) && ((rd_err & bit_q) == '0)));
  assign issue       = scan_q < fill_q;
  assign kprod       = PW'(x_q) * PW'(Recip100);
  assign err_start   = accept && (req_i.req_type == ReqSample) && armed_q;

  always_comb begin
    state_d      = state_q;
    rate_d       = rate_q;
    window_d     = window_q;
    armed_d      = armed_q;
    prev_d       = prev_q;
    host_d       = host_q;
    widx_d       = widx_q;
    fill_d       = fill_q;
    addr_d       = addr_q;
    scan_d       = scan_q;
    rv_d         = 1'b0;
    newest_d     = newest_q;
    cnt_d        = cnt_q;
    count_pass_d = count_pass_q;
    x_d          = x_q;
    k_d          = k_q;
    bit_d        = bit_q;
    mask_d       = mask_q;
    prefix_d     = prefix_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSampleRate: rate_d   = cfg_data_i[26:0];
        CfgWindow:     window_d = cfg_data_i;
        default:       rate_d   = rate_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == ReqSample) begin
            armed_d = 1'b1;
            prev_d  = req_i.host_us;
            host_d  = req_i.host_us;
            if (armed_q) begin
              state_d = ST_SAMPLE;
            end
          end else if (fill_q == '0) begin
            // Empty ring: answer at once.
            res_d       = '{p95_error_us: 32'd0, enough_samples: 1'b0};
            res_valid_d = 1'b1;
          end else begin
            addr_d  = newest_slot;
            state_d = ST_NEWEST;
          end
        end
      end
      ST_SAMPLE: begin
        // Hold until the error unit finishes, then advance the ring.
        if (err_done) begin
          widx_d  = (widx_q == IdxW'(RingDepth - 1)) ? '0 : widx_q + IdxW'(1);
          if (fill_q != CntW'(RingDepth)) begin
            fill_d = fill_q + CntW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_NEWEST: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        newest_d     = rd_time;
        scan_d       = '0;
        cnt_d        = '0;
        count_pass_d = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue) begin
          scan_d = scan_q + CntW'(1);
          addr_d = addr_dec;
          rv_d   = 1'b1;
        end
        if (rv_q && hit) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (!issue && !rv_q) begin
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        scan_d = '0;
        addr_d = newest_slot;
        cnt_d  = '0;
        if (count_pass_q) begin
          if (cnt_q < CntW'(MinEntries)) begin
            res_d       = '{p95_error_us: 32'd0, enough_samples: 1'b0};
            res_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            x_d     = XW'(cnt_q) * XW'(PctNum);
            state_d = ST_KCALC;
          end
        end else begin
          // Settle one bit of the answer.
          if (k_q >= cnt_q) begin
            k_d      = k_q - cnt_q;
            prefix_d = prefix_q | bit_q;
          end
          mask_d = mask_q | bit_q;
          bit_d  = {1'b0, bit_q[31:1]};
          if (bit_q[0]) begin
            res_d       = '{p95_error_us: prefix_q | ((k_q >= cnt_q) ? bit_q : 32'd0),
                            enough_samples: 1'b1};
            res_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_KCALC: begin
        k_d          = kprod[32 +: CntW];
        bit_d        = 32'h8000_0000;
        mask_d       = '0;
        prefix_d     = '0;
        count_pass_d = 1'b0;
        state_d      = ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rate_q       <= SampleRateRst;
      window_q     <= WindowRst;
      armed_q      <= 1'b0;
      prev_q       <= '0;
      widx_q       <= '0;
      fill_q       <= '0;
      scan_q       <= '0;
      rv_q         <= 1'b0;
      count_pass_q <= 1'b1;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rate_q       <= rate_d;
      window_q     <= window_d;
      armed_q      <= armed_d;
      prev_q       <= prev_d;
      widx_q       <= widx_d;
      fill_q       <= fill_d;
      scan_q       <= scan_d;
      rv_q         <= rv_d;
      count_pass_q <= count_pass_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    host_q   <= host_d;
    addr_q   <= addr_d;
    newest_q <= newest_d;
    cnt_q    <= cnt_d;
    x_q      <= x_d;
    k_q      <= k_d;
    bit_q    <= bit_d;
    mask_q   <= mask_d;
    prefix_q <= prefix_d;
    res_q    <= res_d;
  end

  ijp_err u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (err_start),
    .actual_i (req_i.host_us - prev_q),
    .count_i  (req_i.buf_samples),
    .rate_i   (rate_q),
    .done_o   (err_done),
    .err_o    (err_val)
  );

  ijp_ram #(
    .Width (96),
    .Depth (RingDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (err_done),
    .waddr_i (widx_q),
    .wdata_i ({host_q, err_val}),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;
  assign short_res      = result_valid_o && !result_o.enough_samples;

  `IJP_ASSERT(a_fill_bound, fill_q <= CntW'(RingDepth), "fill count above ring depth")
  `IJP_ASSERT(a_short_zero, short_res |-> result_o.p95_error_us == 32'd0, "short result not zero")
  `IJP_ASSERT(a_done_in_sample, err_done |-> state_q == ST_SAMPLE, "error unit done outside a sample")
  `IJP_ASSERT(a_result_idle, result_valid_o |-> !busy, "result shown while busy")

endmodule

// ===== hdl/ijp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ijp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ijp_err.sv =====
// Interval error unit: |interval - count*1e6/rate|, rounded and capped.
// Depends on ijp_pkg. Shift-add multiply, then restoring division.
module ijp_err (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] actual_i,
  input  logic [31:0] count_i,
  input  logic [26:0] rate_i,
  output logic        done_o,
  output logic [31:0] err_o
);
  import ijp_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL  = 4'b0010,
    E_DIFF = 4'b0100,
    E_DIV  = 4'b1000
  } err_state_e;

  err_state_e  state_q, state_d;
  logic [5:0]  step_q, step_d;
  logic [90:0] act_q, act_d, prod_q, prod_d;
  logic [51:0] cnt_q, cnt_d, expd_q, expd_d;
  logic [26:0] r_q, r_d, rsh_q, rsh_d;
  logic [19:0] ksh_q, ksh_d;
  logic [92:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [32:0] quo_q, quo_d;
  logic        sat_q, sat_d;
  logic        done_q, done_d;
  logic [90:0] diff;
  logic [92:0] num;

  always_comb begin
    diff = (prod_q >= {39'd0, expd_q}) ? prod_q - {39'd0, expd_q}
                                       : {39'd0, expd_q} - prod_q;
    num  = {1'b0, diff, 1'b0} + {66'd0, r_q};
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    act_d   = act_q;
    prod_d  = prod_q;
    cnt_d   = cnt_q;
    expd_d  = expd_q;
    r_d     = r_q;
    rsh_d   = rsh_q;
    ksh_d   = ksh_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    sat_d   = sat_q;
    done_d  = 1'b0;
    case (state_q)
      E_IDLE: begin
        if (start_i) begin
          act_d   = {27'd0, actual_i};
          r_d     = (rate_i == 27'd0) ? 27'd1 : rate_i;
          rsh_d   = (rate_i == 27'd0) ? 27'd1 : rate_i;
          cnt_d   = {20'd0, count_i};
          ksh_d   = UsPerSecond;
          prod_d  = '0;
          expd_d  = '0;
          step_d  = '0;
          state_d = E_MUL;
        end
      end
      E_MUL: begin
        if (rsh_q[0]) begin
          prod_d = prod_q + act_q;
        end
        if (ksh_q[0]) begin
          expd_d = expd_q + cnt_q;
        end
        act_d  = {act_q[89:0], 1'b0};
        cnt_d  = {cnt_q[50:0], 1'b0};
        rsh_d  = {1'b0, rsh_q[26:1]};
        ksh_d  = {1'b0, ksh_q[19:1]};
        step_d = step_q + 6'd1;
        if (step_q == 6'd26) begin
          state_d = E_DIFF;
        end
      end
      E_DIFF: begin
        rem_d   = num;
        dvs_d   = {33'd0, r_q, 1'b0, 32'd0};
        sat_d   = (num >= {32'd0, r_q, 1'b0, 33'd0});
        quo_d   = '0;
        step_d  = '0;
        state_d = E_DIV;
      end
      E_DIV: begin
        if (rem_q >= dvs_q) begin
          rem_d = rem_q - dvs_q;
          quo_d = {quo_q[31:0], 1'b1};
        end else begin
          quo_d = {quo_q[31:0], 1'b0};
        end
        dvs_d  = {1'b0, dvs_q[92:1]};
        step_d = step_q + 6'd1;
        if (step_q == 6'd32) begin
          done_d  = 1'b1;
          state_d = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
    expd_q <= expd_d;
    r_q    <= r_d;
    rsh_q  <= rsh_d;
    ksh_q  <= ksh_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    sat_q  <= sat_d;
  end

  assign done_o = done_q;
  assign err_o  = (sat_q || (quo_q > {1'b0, ErrorCap})) ? ErrorCap : quo_q[31:0];

endmodule
